FILE: rtl/wwrl_pkg.sv
// ----------------------------------------------------------------------------
// wwrl_pkg
// Shared types and codes of the wound-wait row lock manager.
// ----------------------------------------------------------------------------
package wwrl_pkg;

    localparam int SLOT_W  = 4;
    localparam int STAMP_W = 64;
    localparam int MASK_W  = 16;
    localparam int EV_W    = 3;

    typedef logic [SLOT_W-1:0] t_slot;

    // Result event codes.
    typedef enum logic [EV_W-1:0] {
        EV_WOUND   = 3'd0,
        EV_PROMOTE = 3'd1,
        EV_GRANT   = 3'd2,
        EV_WAIT    = 3'd3,
        EV_DONE    = 3'd4
    } t_event;

    // Per-slot entry status.
    typedef enum logic [1:0] {
        ST_DROPPED = 2'd0,
        ST_OWNER   = 2'd1,
        ST_WAITER  = 2'd2
    } t_status;

    // Mode held on the row.
    typedef enum logic [1:0] {
        HELD_NONE   = 2'd0,
        HELD_SHARED = 2'd1,
        HELD_EXCL   = 2'd2
    } t_held;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_GRANT,
        OP_OREM,
        OP_WREM,
        OP_DROP,
        OP_WOUND,
        OP_SETENT,
        OP_INSERT,
        OP_PROMOTE,
        OP_FINAL
    } t_op;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_ROWN,
        S_RWAIT,
        S_GRANT,
        S_WRD,
        S_WCMP,
        S_SETENT,
        S_IRD,
        S_ICMP,
        S_IPUT,
        S_PROMO,
        S_FIN4,
        S_FINA
    } t_state;

    typedef struct packed {
        t_op    op;
        logic   idx_clr;
        logic   idx_inc;
        logic   rd_waiter;
        t_event fin_ev;
    } t_cmd;

    typedef struct packed {
        logic    oor;
        logic    kind;
        t_status slot_stat;
        logic    owner_zero;
        logic    idx_end_own;
        logic    idx_end_wait;
        logic    own_hit;
        logic    wait_hit;
        logic    wound_hit;
        logic    wound_blocked;
        logic    ins_after;
        logic    can_promote;
        logic    out_free;
        logic    slot_owner;
        logic    held_none;
    } t_stat;

endpackage

FILE: rtl/wwrl_if.sv
// ----------------------------------------------------------------------------
// wwrl_if
// Request and result channels of the row lock manager.
// ----------------------------------------------------------------------------
interface wwrl_req_if;
    import wwrl_pkg::*;
    logic                valid;
    logic                ready;
    logic                kind;
    t_slot               slot;
    logic [STAMP_W-1:0]  stamp;
    logic                mode;
    logic [MASK_W-1:0]   unwoundable_mask;
    modport source (output valid, kind, slot, stamp, mode, unwoundable_mask, input ready);
    modport sink   (input valid, kind, slot, stamp, mode, unwoundable_mask, output ready);
endinterface

interface wwrl_res_if;
    import wwrl_pkg::*;
    logic            valid;
    logic            ready;
    logic [EV_W-1:0] event_res;
    t_slot           target;
    logic            last;
    modport source (output valid, event_res, target, last, input ready);
    modport sink   (input valid, event_res, target, last, output ready);
endinterface

FILE: rtl/wwrl_ram.sv
// ----------------------------------------------------------------------------
// wwrl_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wwrl_ram #(
    parameter int W = 64,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/wwrl_ctrl.sv
// ----------------------------------------------------------------------------
// wwrl_ctrl
// Sequencer of the lock manager: walks owner and waiter lists per request.
// ----------------------------------------------------------------------------
module wwrl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  wwrl_pkg::t_stat i_stat,
    output wwrl_pkg::t_cmd  o_cmd
);
    import wwrl_pkg::*;

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        o_cmd.op        = OP_NONE;
        o_cmd.idx_clr   = 1'b0;
        o_cmd.idx_inc   = 1'b0;
        o_cmd.rd_waiter = 1'b0;
        o_cmd.fin_ev    = EV_DONE;
        o_in_ready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.idx_clr = 1'b1;
                if (i_stat.oor) begin
                    n_state = S_FIN4;
                end else if (i_stat.kind) begin
                    if (i_stat.slot_stat == ST_OWNER) begin
                        n_state = S_ROWN;
                    end else if (i_stat.slot_stat == ST_WAITER) begin
                        n_state = S_RWAIT;
                    end else begin
                        o_cmd.op = OP_DROP;
                        n_state  = S_PROMO;
                    end
                end else if (i_stat.slot_stat != ST_DROPPED) begin
                    n_state = S_FIN4;
                end else if (i_stat.owner_zero) begin
                    n_state = S_GRANT;
                end else begin
                    n_state = S_WRD;
                end
            end
            S_ROWN: begin
                if (i_stat.idx_end_own) begin
                    o_cmd.op = OP_DROP;
                    n_state  = S_PROMO;
                end else if (i_stat.own_hit) begin
                    o_cmd.op = OP_OREM;
                    n_state  = S_PROMO;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_RWAIT: begin
                if (i_stat.idx_end_wait) begin
                    o_cmd.op = OP_DROP;
                    n_state  = S_PROMO;
                end else if (i_stat.wait_hit) begin
                    o_cmd.op = OP_WREM;
                    n_state  = S_PROMO;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_GRANT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_GRANT;
                    n_state  = S_IDLE;
                end
            end
            // The stamp read of the current owner is under way.
            S_WRD: begin
                n_state = i_stat.idx_end_own ? S_SETENT : S_WCMP;
            end
            S_WCMP: begin
                if (i_stat.wound_hit) begin
                    if (i_stat.wound_blocked) begin
                        n_state = S_FIN4;
                    end else if (i_stat.out_free) begin
                        o_cmd.op = OP_WOUND;
                        n_state  = S_WRD;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_WRD;
                end
            end
            S_SETENT: begin
                o_cmd.op        = OP_SETENT;
                o_cmd.idx_clr   = 1'b1;
                o_cmd.rd_waiter = 1'b1;
                n_state         = S_IRD;
            end
            S_IRD: begin
                o_cmd.rd_waiter = 1'b1;
                n_state = i_stat.idx_end_wait ? S_IPUT : S_ICMP;
            end
            S_ICMP: begin
                o_cmd.rd_waiter = 1'b1;
                if (i_stat.ins_after) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_IRD;
                end else begin
                    n_state = S_IPUT;
                end
            end
            S_IPUT: begin
                o_cmd.op = OP_INSERT;
                n_state  = S_PROMO;
            end
            S_PROMO: begin
                if (i_stat.can_promote) begin
                    if (i_stat.out_free) begin
                        o_cmd.op = OP_PROMOTE;
                    end
                end else begin
                    n_state = i_stat.kind ? S_FIN4 : S_FINA;
                end
            end
            S_FIN4: begin
                if (i_stat.out_free) begin
                    o_cmd.op     = OP_FINAL;
                    o_cmd.fin_ev = EV_DONE;
                    n_state      = S_IDLE;
                end
            end
            S_FINA: begin
                if (i_stat.out_free) begin
                    o_cmd.op     = OP_FINAL;
                    o_cmd.fin_ev = i_stat.slot_owner ? EV_GRANT : EV_WAIT;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

FILE: rtl/wwrl_dpath.sv
// ----------------------------------------------------------------------------
// wwrl_dpath
// Lock state, owner stack, waiter queue, stamp RAM and result register.
// ----------------------------------------------------------------------------
module wwrl_dpath #(
    parameter int SLOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wwrl_pkg::t_cmd               i_cmd,
    output wwrl_pkg::t_stat              o_stat,
    input  logic                         i_kind,
    input  wwrl_pkg::t_slot              i_slot,
    input  logic [wwrl_pkg::STAMP_W-1:0] i_stamp,
    input  logic                         i_mode,
    input  logic [wwrl_pkg::MASK_W-1:0]  i_mask,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [wwrl_pkg::EV_W-1:0]    o_event_res,
    output wwrl_pkg::t_slot              o_target,
    output logic                         o_last
);
    import wwrl_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // Request registers.
    logic               r_kind, n_kind;
    t_slot              r_slot, n_slot;
    logic [STAMP_W-1:0] r_stamp, n_stamp;
    logic               r_mode, n_mode;
    logic [MASK_W-1:0]  r_mask, n_mask;

    // Lock state.
    t_status            r_status [SLOTS];
    t_status            n_status [SLOTS];
    logic [SLOTS-1:0]   r_emode, n_emode;
    t_slot              r_owner  [SLOTS];
    t_slot              n_owner  [SLOTS];
    t_slot              r_waiter [SLOTS];
    t_slot              n_waiter [SLOTS];
    logic [CW-1:0]      r_ocnt, n_ocnt;
    logic [CW-1:0]      r_wcnt, n_wcnt;
    t_held              r_held, n_held;
    logic [CW-1:0]      r_idx, n_idx;

    // Result register.
    logic               r_ov, n_ov;
    t_event             r_oev, n_oev;
    t_slot              r_otgt, n_otgt;
    logic               r_olast, n_olast;

    logic [IW-1:0]      s_ix, idx_ix, e_ix, h_ix, o0_ix, raddr;
    t_slot              cur_owner, cur_waiter, head;
    logic               we;
    logic [STAMP_W-1:0] rdata;
    logic               conflict;

    assign s_ix       = IW'(r_slot);
    assign idx_ix     = r_idx[IW-1:0];
    assign cur_owner  = r_owner[idx_ix];
    assign cur_waiter = r_waiter[idx_ix];
    assign head       = r_waiter[0];
    assign e_ix       = IW'(cur_owner);
    assign h_ix       = IW'(head);
    assign o0_ix      = IW'(r_owner[0]);
    assign raddr      = IW'(i_cmd.rd_waiter ? cur_waiter : cur_owner);
    assign we         = (i_cmd.op == OP_GRANT) || (i_cmd.op == OP_SETENT);

    // Entry timestamps.
    wwrl_ram #(.W(STAMP_W), .D(SLOTS)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (s_ix),
        .i_wdata (r_stamp),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Status toward the controller.
    assign conflict = (r_held != HELD_NONE) && ((r_held == HELD_EXCL) || r_mode);
    always_comb begin
        o_stat.oor           = 32'(r_slot) >= SLOTS;
        o_stat.kind          = r_kind;
        o_stat.slot_stat     = r_status[s_ix];
        o_stat.owner_zero    = r_ocnt == '0;
        o_stat.idx_end_own   = r_idx >= r_ocnt;
        o_stat.idx_end_wait  = r_idx >= r_wcnt;
        o_stat.own_hit       = cur_owner == r_slot;
        o_stat.wait_hit      = cur_waiter == r_slot;
        o_stat.wound_hit     = (rdata > r_stamp) && conflict;
        o_stat.wound_blocked = r_mask[cur_owner];
        o_stat.ins_after     = r_stamp > rdata;
        o_stat.can_promote   = (r_wcnt != '0) &&
                               ((r_ocnt == '0) || !(r_emode[o0_ix] || r_emode[h_ix]));
        o_stat.out_free      = !r_ov || i_out_ready;
        o_stat.slot_owner    = r_status[s_ix] == ST_OWNER;
        o_stat.held_none     = r_held == HELD_NONE;
    end

    // Next-state logic for every operation.
    always_comb begin
        n_kind   = r_kind;
        n_slot   = r_slot;
        n_stamp  = r_stamp;
        n_mode   = r_mode;
        n_mask   = r_mask;
        n_status = r_status;
        n_emode  = r_emode;
        n_owner  = r_owner;
        n_waiter = r_waiter;
        n_ocnt   = r_ocnt;
        n_wcnt   = r_wcnt;
        n_held   = r_held;
        n_oev    = r_oev;
        n_otgt   = r_otgt;
        n_olast  = r_olast;
        n_ov     = r_ov && !i_out_ready;
        case (i_cmd.op)
            OP_LOAD: begin
                n_kind  = i_kind;
                n_slot  = i_slot;
                n_stamp = i_stamp;
                n_mode  = i_mode;
                n_mask  = i_mask;
            end
            OP_GRANT: begin
                n_emode[s_ix]  = r_mode;
                n_owner[0]     = r_slot;
                n_ocnt         = CW'(1);
                n_status[s_ix] = ST_OWNER;
                n_held         = r_mode ? HELD_EXCL : HELD_SHARED;
                n_ov           = 1'b1;
                n_oev          = EV_GRANT;
                n_otgt         = r_slot;
                n_olast        = 1'b1;
            end
            OP_OREM, OP_WOUND: begin
                for (int k = 0; k + 1 < SLOTS; k++) begin
                    if (k >= int'(r_idx)) begin
                        n_owner[k] = r_owner[k+1];
                    end
                end
                n_ocnt = r_ocnt - CW'(1);
                if (r_ocnt == CW'(1)) begin
                    n_held = HELD_NONE;
                end
                if (i_cmd.op == OP_WOUND) begin
                    n_status[e_ix] = ST_DROPPED;
                    n_ov           = 1'b1;
                    n_oev          = EV_WOUND;
                    n_otgt         = cur_owner;
                    n_olast        = 1'b0;
                end else begin
                    n_status[s_ix] = ST_DROPPED;
                end
            end
            OP_WREM: begin
                for (int k = 0; k + 1 < SLOTS; k++) begin
                    if (k >= int'(r_idx)) begin
                        n_waiter[k] = r_waiter[k+1];
                    end
                end
                n_wcnt         = r_wcnt - CW'(1);
                n_status[s_ix] = ST_DROPPED;
            end
            OP_DROP: begin
                n_status[s_ix] = ST_DROPPED;
            end
            OP_SETENT: begin
                n_emode[s_ix] = r_mode;
            end
            OP_INSERT: begin
                for (int k = 1; k < SLOTS; k++) begin
                    if (k > int'(r_idx)) begin
                        n_waiter[k] = r_waiter[k-1];
                    end
                end
                n_waiter[idx_ix] = r_slot;
                n_wcnt           = r_wcnt + CW'(1);
                n_status[s_ix]   = ST_WAITER;
            end
            OP_PROMOTE: begin
                for (int k = 0; k + 1 < SLOTS; k++) begin
                    n_waiter[k] = r_waiter[k+1];
                end
                for (int k = 1; k < SLOTS; k++) begin
                    n_owner[k] = r_owner[k-1];
                end
                n_owner[0]     = head;
                n_wcnt         = r_wcnt - CW'(1);
                n_ocnt         = r_ocnt + CW'(1);
                n_status[h_ix] = ST_OWNER;
                n_held         = r_emode[h_ix] ? HELD_EXCL : HELD_SHARED;
                n_ov           = 1'b1;
                n_oev          = EV_PROMOTE;
                n_otgt         = head;
                n_olast        = 1'b0;
            end
            OP_FINAL: begin
                n_ov    = 1'b1;
                n_oev   = i_cmd.fin_ev;
                n_otgt  = r_slot;
                n_olast = 1'b1;
            end
            default: begin
            end
        endcase
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + CW'(1);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_status[k] <= ST_DROPPED;
            end
            r_emode <= '0;
            r_ocnt  <= '0;
            r_wcnt  <= '0;
            r_held  <= HELD_NONE;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_status <= n_status;
            r_emode  <= n_emode;
            r_ocnt   <= n_ocnt;
            r_wcnt   <= n_wcnt;
            r_held   <= n_held;
            r_idx    <= n_idx;
            r_ov     <= n_ov;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_slot   <= n_slot;
        r_stamp  <= n_stamp;
        r_mode   <= n_mode;
        r_mask   <= n_mask;
        r_owner  <= n_owner;
        r_waiter <= n_waiter;
        r_oev    <= n_oev;
        r_otgt   <= n_otgt;
        r_olast  <= n_olast;
    end

    assign o_out_valid = r_ov;
    assign o_event_res = r_oev;
    assign o_target    = r_otgt;
    assign o_last      = r_olast;
endmodule

FILE: rtl/wound_wait_row_lock.sv
// ----------------------------------------------------------------------------
// wound_wait_row_lock
// Wound-wait lock manager for one row: grants, wounds, queues and promotes.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  i_req    in   valid/ready    kind, slot, stamp, mode, unwoundable_mask
//  o_res    out  valid/ready    event_res, target, last
//
// One request is in work at a time. A queued acquire walks the owners in the
// wound walk, passes waiters in the queue insertion and then promotes; a
// release scans the entries before its own and then promotes.
// Synchronous active-low reset clears all entries; no clearing pass is needed.
// A stalled result beat stalls the walk until it is taken.
// ----------------------------------------------------------------------------
module wound_wait_row_lock #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wwrl_req_if.sink    i_req,
    wwrl_res_if.source  o_res
);
    import wwrl_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    wwrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wwrl_dpath #(.SLOTS(SLOTS)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_kind      (i_req.kind),
        .i_slot      (i_req.slot),
        .i_stamp     (i_req.stamp),
        .i_mode      (i_req.mode),
        .i_mask      (i_req.unwoundable_mask),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_event_res (o_res.event_res),
        .o_target    (o_res.target),
        .o_last      (o_res.last)
    );

    // A result is never written over a beat that is still waiting.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_GRANT || cmd.op == OP_WOUND || cmd.op == OP_PROMOTE ||
         cmd.op == OP_FINAL) |-> stat.out_free)
        else $error("result emitted while output register busy");

    // Only one request is taken at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is in work");

    // The held mode is none exactly when there are no owners.
    a_held_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.owner_zero == stat.held_none)
        else $error("held mode disagrees with owner count");
endmodule

FILE: sim/wound_wait_row_lock_checker.sv
// ----------------------------------------------------------------------------
// wound_wait_row_lock_checker
// Watches the request and result channels of the row lock manager, keeps its
// own copy of the lock state, predicts the result beats of every accepted
// request and compares them in order with the beats the block returns.
// ----------------------------------------------------------------------------
module wound_wait_row_lock_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wwrl_req_if.sink   i_req,
    wwrl_res_if.sink   i_res,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_req_count,
    output int         o_res_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import wwrl_pkg::*;

    localparam int NSLOT  = 16;
    localparam int MAXRES = 32;

    typedef struct packed {
        t_event ev;
        t_slot  tgt;
        logic   last;
    } t_beat;

    // Lock state mirror.
    t_status            lk_status [NSLOT];
    logic               lk_mode   [NSLOT];
    logic [STAMP_W-1:0] lk_stamp  [NSLOT];
    t_slot              owners    [NSLOT];
    t_slot              waiters   [NSLOT];
    int                 n_owners;
    int                 n_waiters;
    t_held              held;

    t_beat beat_q[$];
    int    n_emit;

    function automatic bit clash(t_held h, logic m);
        if (h == HELD_NONE) return 1'b0;
        return (h == HELD_EXCL) || m;
    endfunction

    function automatic void push_beat(t_event ev, t_slot tgt, logic last);
        if (n_emit >= (last ? MAXRES : MAXRES - 1)) return;
        beat_q.push_back('{ev, tgt, last});
        n_emit++;
    endfunction

    function automatic void drop_owner(int i);
        for (int k = i; k + 1 < n_owners; k++) owners[k] = owners[k+1];
        n_owners--;
        if (n_owners == 0) held = HELD_NONE;
    endfunction

    // Move compatible waiters from the queue head onto the owner stack.
    function automatic void promote_waiters();
        t_slot h;
        while (n_waiters > 0) begin
            h = waiters[0];
            if (n_owners != 0 && clash(t_held'({1'b0, lk_mode[owners[0]]} + 2'd1),
                                       lk_mode[h]))
                break;
            for (int k = 0; k + 1 < n_waiters; k++) waiters[k] = waiters[k+1];
            n_waiters--;
            for (int k = n_owners; k > 0; k--) owners[k] = owners[k-1];
            owners[0] = h;
            n_owners++;
            lk_status[h] = ST_OWNER;
            held = t_held'({1'b0, lk_mode[h]} + 2'd1);
            push_beat(EV_PROMOTE, h, 1'b0);
        end
    endfunction

    function automatic void predict_lock(logic kind, t_slot s, logic [STAMP_W-1:0] st,
                                         logic m, logic [MASK_W-1:0] mask);
        int i;
        t_slot e;
        n_emit = 0;
        if (kind) begin
            if (lk_status[s] == ST_OWNER) begin
                for (i = 0; i < n_owners; i++)
                    if (owners[i] == s) begin
                        drop_owner(i);
                        break;
                    end
            end else if (lk_status[s] == ST_WAITER) begin
                for (i = 0; i < n_waiters; i++)
                    if (waiters[i] == s) begin
                        for (int k = i; k + 1 < n_waiters; k++) waiters[k] = waiters[k+1];
                        n_waiters--;
                        break;
                    end
            end
            lk_status[s] = ST_DROPPED;
            promote_waiters();
            push_beat(EV_DONE, s, 1'b1);
            return;
        end
        if (lk_status[s] != ST_DROPPED) begin
            push_beat(EV_DONE, s, 1'b1);
            return;
        end
        if (n_owners == 0) begin
            lk_mode[s] = m;
            lk_stamp[s] = st;
            owners[0] = s;
            n_owners = 1;
            lk_status[s] = ST_OWNER;
            held = t_held'({1'b0, m} + 2'd1);
            push_beat(EV_GRANT, s, 1'b1);
            return;
        end
        // Wound walk over younger conflicting owners.
        i = 0;
        while (i < n_owners) begin
            e = owners[i];
            if (lk_stamp[e] > st && clash(held, m)) begin
                if (mask[e]) begin
                    push_beat(EV_DONE, s, 1'b1);
                    return;
                end
                drop_owner(i);
                lk_status[e] = ST_DROPPED;
                push_beat(EV_WOUND, e, 1'b0);
            end else begin
                i++;
            end
        end
        lk_mode[s] = m;
        lk_stamp[s] = st;
        i = 0;
        while (i < n_waiters && st > lk_stamp[waiters[i]]) i++;
        for (int k = n_waiters; k > i; k--) waiters[k] = waiters[k-1];
        waiters[i] = s;
        n_waiters++;
        lk_status[s] = ST_WAITER;
        promote_waiters();
        push_beat(lk_status[s] == ST_OWNER ? EV_GRANT : EV_WAIT, s, 1'b1);
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] checker: %s", $realtime, what);
        o_fail_count++;
    endtask

    assign o_pending = beat_q.size();

    always @(posedge i_clk) begin
        t_beat exp_b;
        if (!i_rst_n) begin
            for (int k = 0; k < NSLOT; k++) begin
                lk_status[k] = ST_DROPPED;
                lk_mode[k] = 1'b0;
            end
            n_owners = 0;
            n_waiters = 0;
            held = HELD_NONE;
            beat_q.delete();
            o_fail_count = 0;
            o_req_count = 0;
            o_res_count = 0;
        end else begin
            // Result beat compare against the oldest prediction.
            if (i_res.valid && i_res.ready) begin
                o_res_count++;
                if (beat_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat ev=%0d tgt=%0d",
                                              i_res.event_res, i_res.target));
                end else begin
                    exp_b = beat_q.pop_front();
                    if (i_res.event_res !== exp_b.ev || i_res.target !== exp_b.tgt ||
                        i_res.last !== exp_b.last)
                        report_mismatch($sformatf(
                            "got ev=%0d tgt=%0d last=%0b, want ev=%0d tgt=%0d last=%0b",
                            i_res.event_res, i_res.target, i_res.last,
                            exp_b.ev, exp_b.tgt, exp_b.last));
                end
            end
            if (i_req.valid && i_req.ready) begin
                o_req_count++;
                predict_lock(i_req.kind, i_req.slot, i_req.stamp, i_req.mode,
                             i_req.unwoundable_mask);
            end
        end
    end
endmodule

FILE: sim/wound_wait_row_lock_tb.sv
// ----------------------------------------------------------------------------
// wound_wait_row_lock_tb
// Drives directed and random acquire and release beats into the row lock
// manager with random gaps and result stalls; a checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module wound_wait_row_lock_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wwrl_pkg::*;

    localparam int N_RANDOM = 210;
    localparam int IDLE_MAX = 20000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count, pending, req_count, res_count;
    int   idle_cycles;
    int   res_hold;
    bit   res_stall_on;

    wwrl_req_if req_ch();
    wwrl_res_if res_ch();

    wound_wait_row_lock #(.SLOTS(16)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    wound_wait_row_lock_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch.sink),
        .i_res        (res_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_req_count  (req_count),
        .o_res_count  (res_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side stalls: short random ones in some stretches, rare long holds.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            res_stall_on <= 1'b0;
            res_hold <= 0;
        end else begin
            if ($urandom_range(0, 63) == 0) res_stall_on <= ~res_stall_on;
            if (res_hold != 0) begin
                res_hold <= res_hold - 1;
                res_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 199) == 0) begin
                res_hold <= $urandom_range(10, 40);
                res_ch.ready <= 1'b0;
            end else if (!res_stall_on) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(0, 9) < 6);
            end
        end
    end

    task automatic send_beat(logic kind, t_slot s, logic [STAMP_W-1:0] st, logic m,
                             logic [MASK_W-1:0] mask);
        int g;
        g = gap_len();
        if (g > 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind <= kind;
        req_ch.slot <= s;
        req_ch.stamp <= st;
        req_ch.mode <= m;
        req_ch.unwoundable_mask <= mask;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    function automatic logic [STAMP_W-1:0] rand_stamp();
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return STAMP_W'($urandom_range(0, 40));
            2: return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, $urandom};
            default: return STAMP_W'($urandom_range(0, 1000));
        endcase
    endfunction

    // Watchdog on cycles with no accepted beat.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_MAX) begin
            $display("watchdog: no beat for %0d cycles", IDLE_MAX);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic m;
        t_slot s;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = 1'b0;
        req_ch.slot = '0;
        req_ch.stamp = '0;
        req_ch.mode = 1'b0;
        req_ch.unwoundable_mask = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: grant on empty row, shared sharing, wounds, abort, refusals.
        send_beat(1'b0, 4'd0, 64'd100, 1'b0, 16'h0000);       // grant on empty row
        send_beat(1'b0, 4'd1, 64'd200, 1'b0, 16'h0000);       // shared joins shared
        send_beat(1'b0, 4'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
        send_beat(1'b0, 4'd0, 64'd5, 1'b1, 16'h0000);         // already owner: refused
        send_beat(1'b0, 4'd3, 64'd150, 1'b1, 16'h0004);       // blocked by committing 2
        send_beat(1'b0, 4'd4, 64'd50, 1'b1, 16'h0001);        // blocked by committing 0
        send_beat(1'b1, 4'd7, 64'd0, 1'b0, 16'h0000);         // release with no entry
        send_beat(1'b0, 4'd5, 64'd0, 1'b1, 16'h0000);         // oldest wounds all
        send_beat(1'b0, 4'd6, 64'd300, 1'b0, 16'hFFFF);
        send_beat(1'b0, 4'd15, 64'd300, 1'b0, 16'h0000);      // equal stamp tie
        send_beat(1'b1, 4'd5, 64'd0, 1'b0, 16'h0000);         // release promotes
        send_beat(1'b1, 4'd3, '1, 1'b1, 16'hFFFF);
        send_beat(1'b1, 4'd6, 64'd0, 1'b0, 16'h0000);
        send_beat(1'b1, 4'd15, 64'd0, 1'b0, 16'h0000);
        send_beat(1'b0, 4'd15, 64'h8000_0000_0000_0000, 1'b1, 16'h8000);
        send_beat(1'b0, 4'd8, 64'd1, 1'b1, 16'h8000);         // abort on slot 15
        send_beat(1'b0, 4'd9, 64'd2, 1'b0, 16'h7FFF);         // wound slot 15
        send_beat(1'b1, 4'd9, 64'd0, 1'b0, 16'h0000);

        // Random: mostly acquire/release traffic over a small working set.
        for (int n = 0; n < N_RANDOM; n++) begin
            s = (n % 40 < 25) ? t_slot'($urandom_range(0, 5)) : t_slot'($urandom);
            m = $urandom_range(0, 2) == 0;
            send_beat($urandom_range(0, 9) < 4, s, rand_stamp(), m,
                      ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000);
        end
        req_ch.valid <= 1'b0;

        // Drain expected beats, then let the block settle.
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sent %0d lock requests (directed and random), checked %0d result beats.",
                 req_count, res_count);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/wwrl_pkg.sv
rtl/wwrl_if.sv
rtl/wwrl_ram.sv
rtl/wwrl_ctrl.sv
rtl/wwrl_dpath.sv
rtl/wound_wait_row_lock.sv
sim/wound_wait_row_lock_checker.sv
sim/wound_wait_row_lock_tb.sv
